@@ hdl/mme_pkg.sv @@
// Shared types and constants for the matrix multiply engine.
// No dependencies; every other file depends on this package.
package mme_pkg;

  localparam int DATA_W    = 32;
  localparam int DIM_W     = 4;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 2;

  // input word opcodes
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_COLS_A = 2'd1,
    CFG_ROWS_B = 2'd2,
    CFG_COLS_B = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_WRITE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             out_load;
    logic             out_last;
    logic             out_bad;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/mme_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on mme_pkg.
interface mme_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [mme_pkg::IDX_W-1:0]     row;
  logic [mme_pkg::IDX_W-1:0]     col;
  logic signed [mme_pkg::DATA_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface mme_out_if;
  logic                          valid;
  logic                          ready;
  logic [mme_pkg::IDX_W-1:0]     out_row;
  logic [mme_pkg::IDX_W-1:0]     out_col;
  logic signed [mme_pkg::DATA_W-1:0] product;
  logic                          last;
  logic                          incompatible;

  modport source (output valid, out_row, out_col, product, last, incompatible, input ready);
  modport sink   (input valid, out_row, out_col, product, last, incompatible, output ready);
endinterface

@@ hdl/mme_datapath.sv @@
// Datapath: A and B element stores, multiply-accumulate pipeline,
// scaling and saturation, and the result output register. Depends on mme_pkg, mme_if.
module mme_datapath #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mme_pkg::dp_cmd_t                  cmd,
  output mme_pkg::dp_status_t               status,
  input  logic [mme_pkg::IDX_W-1:0]         in_row,
  input  logic [mme_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mme_pkg::DATA_W-1:0] in_value,
  mme_out_if.source                         out_ch
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];
  logic [DEPTH-1:0]  vld_a_r;
  logic [DEPTH-1:0]  vld_b_r;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;

  logic [DATA_W-1:0]        rd_a_r, rd_b_r;
  logic                     rd_av_r, rd_bv_r;
  logic                     s1_v_r, s1_first_r, s1_last_r;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_v_r, s2_first_r, s2_last_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;
  logic [DATA_W-1:0]        sat;

  logic                     out_vld_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic [DATA_W-1:0]        out_prod_r;
  logic                     out_last_r, out_bad_r;

  // row-major addresses with stride MAX_DIM
  assign wr_addr   = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
  assign rd_addr_a = ADDR_W'(int'(cmd.i) * MAX_DIM + int'(cmd.k));
  assign rd_addr_b = ADDR_W'(int'(cmd.k) * MAX_DIM + int'(cmd.j));

  // element stores
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= in_value;
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= in_value;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem_a[rd_addr_a];
      rd_b_r <= mem_b[rd_addr_b];
    end
  end

  // written-entry flags, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= '0;
      vld_b_r <= '0;
      rd_av_r <= 1'b0;
      rd_bv_r <= 1'b0;
    end else begin
      if (cmd.wr_a) begin
        vld_a_r[wr_addr] <= 1'b1;
      end
      if (cmd.wr_b) begin
        vld_b_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_av_r <= vld_a_r[rd_addr_a];
        rd_bv_r <= vld_b_r[rd_addr_b];
      end
    end
  end

  assign op_a = rd_av_r ? signed'(rd_a_r) : '0;
  assign op_b = rd_bv_r ? signed'(rd_b_r) : '0;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_v_r     <= 1'b0;
      s2_first_r <= 1'b0;
      s2_last_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_v_r     <= cmd.rd_en;
      s1_first_r <= cmd.first;
      s1_last_r  <= cmd.last_k;
      s2_v_r     <= s1_v_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      done_r     <= s2_v_r && s2_last_r;
    end
  end

  // multiply then accumulate at full precision
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (s2_v_r) begin
      acc_r <= s2_first_r ? prod_ext : acc_r + prod_ext;
    end
  end

  // scale by floor shift and saturate to the word width
  assign shifted = acc_r >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
  assign sat     = fits ? shifted[DATA_W-1:0]
                 : (shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}});

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r  <= cmd.i;
      out_col_r  <= cmd.j;
      out_prod_r <= cmd.out_bad ? '0 : sat;
      out_last_r <= cmd.out_last;
      out_bad_r  <= cmd.out_bad;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.out_row      = out_row_r;
  assign out_ch.out_col      = out_col_r;
  assign out_ch.product      = signed'(out_prod_r);
  assign out_ch.last         = out_last_r;
  assign out_ch.incompatible = out_bad_r;

  assign status.acc_done = done_r;
  assign status.out_free = !out_vld_r || out_ch.ready;

endmodule

@@ hdl/mme_ctrl.sv @@
// Controller: configuration registers, load decode and the state machine
// that walks the product elements and inner index. Depends on mme_pkg.
module mme_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_mode,
  input  logic [mme_pkg::IDX_W-1:0]        in_row,
  input  logic [mme_pkg::IDX_W-1:0]        in_col,
  output mme_pkg::dp_cmd_t                 cmd,
  input  mme_pkg::dp_status_t              status
);
  import mme_pkg::*;

  localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0]  rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [DIM_W-1:0]  ra, ca, rb, cb;
  logic              bad;
  logic              last_k, last_j, last_el;

  function automatic logic [DIM_W-1:0] act_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_D) begin
      r = MAX_D;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(8);
      cols_a_r <= DIM_W'(8);
      rows_b_r <= DIM_W'(8);
      cols_b_r <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS_A: rows_a_r <= cfg_data;
        CFG_COLS_A: cols_a_r <= cfg_data;
        CFG_ROWS_B: rows_b_r <= cfg_data;
        CFG_COLS_B: cols_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // acting sizes and element walk limits
  assign ra      = act_dim(rows_a_r);
  assign ca      = act_dim(cols_a_r);
  assign rb      = act_dim(rows_b_r);
  assign cb      = act_dim(cols_b_r);
  assign bad     = (ca != rb);
  assign last_k  = ({1'b0, k_r} == ca - DIM_W'(1));
  assign last_j  = ({1'b0, j_r} == cb - DIM_W'(1));
  assign last_el = last_j && ({1'b0, i_r} == ra - DIM_W'(1));

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.i        = i_r;
    cmd.j        = j_r;
    cmd.k        = k_r;
    cmd.out_bad  = bad;
    cmd.out_last = last_el;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_LOAD_A: cmd.wr_a = ({1'b0, in_row} < ra) && ({1'b0, in_col} < ca);
            MODE_LOAD_B: cmd.wr_b = ({1'b0, in_row} < rb) && ({1'b0, in_col} < cb);
            MODE_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = bad ? ST_WRITE : ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.rd_en  = 1'b1;
        cmd.first  = (k_r == '0);
        cmd.last_k = last_k;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = ST_WAIT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (status.acc_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (last_el) begin
            state_nxt = ST_IDLE;
          end else begin
            if (last_j) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
            state_nxt = bad ? ST_WRITE : ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the accumulator finishes only while its element is being waited on
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.acc_done |-> state_r == ST_WAIT)
    else $error("accumulator result outside wait state");

  // a result word is loaded only into a free output slot
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  // stores change only on an accepted load word
  a_wr_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_a || cmd.wr_b) |-> (in_valid && in_ready && !cmd.rd_en))
    else $error("store write without accepted load");

  // final element returns the controller to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_last) |=> state_r == ST_IDLE)
    else $error("no return to idle after final element");

endmodule

@@ hdl/matrix_multiply_engine_top.sv @@
// Top level of the matrix multiply engine: controller plus datapath.
// Depends on mme_pkg, mme_if, mme_ctrl and mme_datapath.
//
// Load words (mode 0 for A, 1 for B) are taken one per cycle while idle and
// write one element; loads outside the configured size are dropped. A compute
// word (mode 2) emits rows_a*cols_b result words in row-major order, last marked.
// Each result runs one multiply-accumulate per cycle of the inner dimension
// (cols_a) on the single multiplier, fed by one read port on each element store,
// then drains through the read, product and accumulator registers and is
// written back into the output register. With mismatched sizes the zero
// results skip the multiply-accumulate. A new word is accepted once the last
// result is in the output register. Stores read as zero after reset through
// per-entry written flags, so no clearing pass is needed. Sums keep full
// precision, are shifted right by FRAC_BITS (floor) and saturate to 32 bits.
module matrix_multiply_engine_top #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mme_in_if.sink                        in_ch,
  mme_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data
);
  import mme_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .cmd       (cmd),
    .status    (status)
  );

  // stores, arithmetic and output register
  mme_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_row   (in_ch.row),
    .in_col   (in_ch.col),
    .in_value (in_ch.value),
    .out_ch   (out_ch)
  );

endmodule

@@ test/matrix_multiply_engine_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking test of matrix_multiply_engine_top: loads A and B elements, runs
// products under many size settings, predicts each product word and compares it.
// Depends on mme_pkg, mme_if and the engine RTL; random idling on both channels.
module matrix_multiply_engine_top_test;
  import mme_pkg::*;

  localparam int MAX_DIM        = 8;
  localparam int FRAC_BITS      = 16;
  localparam int RANDOM_ITEMS   = 410;
  localparam int SETTLE_CYCLES  = 20;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] product;
    logic                     last;
    logic                     incompatible;
  } product_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();

  matrix_multiply_engine_top #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted engine state
  logic signed [DATA_W-1:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [DATA_W-1:0] b_elems [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0] reg_rows_a, reg_cols_a, reg_rows_b, reg_cols_b;

  product_word_t expected_products [$];
  product_word_t exp_word;
  int unsigned   mismatch_count;
  int unsigned   counted_items;
  int unsigned   quiet_cycles;
  bit            steady_run;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // size register as the engine uses it
  function automatic int acting_dim(input logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // exact dot product, floor-scaled and saturated
  function automatic logic signed [DATA_W-1:0] dot_element(input int i, input int j,
                                                           input int inner);
    logic signed [127:0] acc;
    logic signed [63:0]  ea;
    logic signed [63:0]  eb;
    logic signed [127:0] scaled;
    acc = '0;
    for (int k = 0; k < inner; k++) begin
      ea = a_elems[i*MAX_DIM + k];
      eb = b_elems[k*MAX_DIM + j];
      acc = acc + ea * eb;
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (scaled < -128'sh80000000) return 32'h80000000;
    return scaled[DATA_W-1:0];
  endfunction

  // product words that one compute word causes
  function automatic void predict_product();
    int ra, ca, rb, cb;
    bit bad;
    product_word_t w;
    ra  = acting_dim(reg_rows_a);
    ca  = acting_dim(reg_cols_a);
    rb  = acting_dim(reg_rows_b);
    cb  = acting_dim(reg_cols_b);
    bad = (ca != rb);
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < cb; j++) begin
        w.row          = IDX_W'(i);
        w.col          = IDX_W'(j);
        w.product      = bad ? '0 : dot_element(i, j, ca);
        w.last         = (i == ra - 1) && (j == cb - 1);
        w.incompatible = bad;
        expected_products.push_back(w);
      end
    end
  endfunction

  // effect of one accepted input word
  function automatic void apply_word(input logic [1:0] mode, input logic [IDX_W-1:0] row,
                                     input logic [IDX_W-1:0] col,
                                     input logic [DATA_W-1:0] value);
    case (mode)
      MODE_LOAD_A: begin
        if (row < acting_dim(reg_rows_a) && col < acting_dim(reg_cols_a))
          a_elems[row*MAX_DIM + col] = value;
      end
      MODE_LOAD_B: begin
        if (row < acting_dim(reg_rows_b) && col < acting_dim(reg_cols_b))
          b_elems[row*MAX_DIM + col] = value;
      end
      MODE_COMPUTE: predict_product();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // result word checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_products.size() == 0) begin
        report_mismatch($sformatf("word (%0d,%0d) product %h with nothing expected",
                                  out_ch.out_row, out_ch.out_col, out_ch.product));
      end else begin
        exp_word = expected_products.pop_front();
        if (out_ch.out_row !== exp_word.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", out_ch.out_row, exp_word.row));
        if (out_ch.out_col !== exp_word.col)
          report_mismatch($sformatf("out_col %0d, expected %0d", out_ch.out_col, exp_word.col));
        if (out_ch.product !== exp_word.product)
          report_mismatch($sformatf("product at (%0d,%0d) %h, expected %h", exp_word.row,
                                    exp_word.col, out_ch.product, exp_word.product));
        if (out_ch.last !== exp_word.last)
          report_mismatch($sformatf("last at (%0d,%0d) %b, expected %b", exp_word.row,
                                    exp_word.col, out_ch.last, exp_word.last));
        if (out_ch.incompatible !== exp_word.incompatible)
          report_mismatch($sformatf("incompatible at (%0d,%0d) %b, expected %b", exp_word.row,
                                    exp_word.col, out_ch.incompatible, exp_word.incompatible));
      end
    end
  end

  // result side stalls
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady_run ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // watchdog on cycles with no activity
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[%0t] watchdog: no word moved for %0d cycles, %0d results pending",
             $realtime, WATCHDOG_LIMIT, expected_products.size());
    $display("** matrix_multiply_engine_top: FAILED **");
    $finish;
  end

  // send one input word, keep valid high for a following word
  task automatic send_word(input logic [1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = steady_run ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.row   <= row;
    in_ch.col   <= col;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    apply_word(mode, row, col, value);
    if (mode != MODE_UNUSED) counted_items++;
  endtask

  task automatic hold_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pause until every pending product word is out
  task automatic wait_drained();
    hold_input();
    while (expected_products.size() != 0) @(posedge clk);
  endtask

  // write all four size registers while the engine is idle
  task automatic program_sizes(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                               input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_A;
    cfg_data  <= ra;
    @(posedge clk);
    reg_rows_a = ra;
    cfg_index <= CFG_COLS_A;
    cfg_data  <= ca;
    @(posedge clk);
    reg_cols_a = ca;
    cfg_index <= CFG_ROWS_B;
    cfg_data  <= rb;
    @(posedge clk);
    reg_rows_b = rb;
    cfg_index <= CFG_COLS_B;
    cfg_data  <= cb;
    @(posedge clk);
    reg_cols_b = cb;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] odd_dim();
    if ($urandom_range(0, 2) == 0) return '0;
    return DIM_W'($urandom_range(9, 15));
  endfunction

  // occasional ignored word or load at a random position
  task automatic send_stray_word();
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) == 0)
        send_word(MODE_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      else
        send_word($urandom_range(0, 1) ? MODE_LOAD_A : MODE_LOAD_B, IDX_W'($urandom),
                  IDX_W'($urandom), rand_value());
    end
  endtask

  // product straight after reset: sizes 8, stores zero
  task automatic test_reset_state();
    send_word(MODE_COMPUTE, '0, '0, '0);
  endtask

  // 2x2 with extreme values: saturation both ways, floor rounding, dropped and ignored words
  task automatic test_extremes();
    program_sizes(4'd2, 4'd2, 4'd2, 4'd2);
    send_word(MODE_LOAD_A, 3'd0, 3'd0, 32'h7FFFFFFF);
    send_word(MODE_LOAD_A, 3'd0, 3'd1, 32'h7FFFFFFF);
    send_word(MODE_LOAD_A, 3'd1, 3'd0, 32'h00000001);
    send_word(MODE_LOAD_A, 3'd1, 3'd1, 32'hFFFFFFFF);
    send_word(MODE_LOAD_B, 3'd0, 3'd0, 32'h7FFFFFFF);
    send_word(MODE_LOAD_B, 3'd0, 3'd1, 32'h80000000);
    send_word(MODE_LOAD_B, 3'd1, 3'd0, 32'h7FFFFFFF);
    send_word(MODE_LOAD_B, 3'd1, 3'd1, 32'h00000001);
    // outside the 2x2 matrix, must be dropped
    send_word(MODE_LOAD_A, 3'd7, 3'd7, 32'hFFFFFFFF);
    send_word(MODE_UNUSED, 3'd5, 3'd2, 32'h12345678);
    send_word(MODE_COMPUTE, 3'd7, 3'd7, 32'hFFFFFFFF);
  endtask

  // inner sizes differ: zero words flagged incompatible
  task automatic test_incompatible();
    program_sizes(4'd3, 4'd2, 4'd5, 4'd1);
    send_word(MODE_COMPUTE, '0, '0, '0);
  endtask

  // register values 0 and above 8, stores kept across size changes
  task automatic test_odd_sizes();
    program_sizes(4'd0, 4'd15, 4'd9, 4'd0);
    send_word(MODE_LOAD_A, 3'd0, 3'd7, 32'h00010000);
    send_word(MODE_COMPUTE, '0, '0, '0);
    program_sizes(4'd15, 4'd0, 4'd0, 4'd9);
    send_word(MODE_COMPUTE, '0, '0, '0);
  endtask

  // random phases: sizes, mostly complete loads, then products
  task automatic test_random_phases();
    int unsigned start;
    int unsigned kind;
    logic [DIM_W-1:0] ra, ca, rb, cb;
    int ar, ac, br, bc;
    bit keep_sizes;
    start = counted_items;
    while (counted_items - start < RANDOM_ITEMS) begin
      kind       = $urandom_range(0, 19);
      keep_sizes = 1'b0;
      if (kind == 0) begin
        ra = 4'd8; ca = 4'd8; rb = 4'd8; cb = 4'd8;
      end else if (kind <= 3) begin
        ra = DIM_W'($urandom_range(1, 8));
        ca = DIM_W'($urandom_range(1, 8));
        rb = (ca == 8) ? DIM_W'($urandom_range(1, 7)) : DIM_W'($urandom_range(ca + 1, 8));
        cb = DIM_W'($urandom_range(1, 8));
      end else if (kind <= 6) begin
        ra = odd_dim();
        ca = $urandom_range(0, 1) ? odd_dim() : DIM_W'($urandom_range(1, 8));
        rb = $urandom_range(0, 1) ? ca : odd_dim();
        cb = odd_dim();
      end else if (kind <= 9) begin
        keep_sizes = 1'b1;
      end else begin
        ra = DIM_W'($urandom_range(1, 4));
        ca = DIM_W'($urandom_range(1, 8));
        rb = ca;
        cb = DIM_W'($urandom_range(1, 4));
      end
      if (!keep_sizes) program_sizes(ra, ca, rb, cb);
      steady_run = ($urandom_range(0, 3) == 0);
      ar = acting_dim(reg_rows_a);
      ac = acting_dim(reg_cols_a);
      br = acting_dim(reg_rows_b);
      bc = acting_dim(reg_cols_b);
      for (int r = 0; r < ar; r++)
        for (int c = 0; c < ac; c++) begin
          if ($urandom_range(0, 9) != 0)
            send_word(MODE_LOAD_A, IDX_W'(r), IDX_W'(c), rand_value());
          send_stray_word();
        end
      if ($urandom_range(0, 3) == 0) wait_drained();
      for (int r = 0; r < br; r++)
        for (int c = 0; c < bc; c++) begin
          if ($urandom_range(0, 9) != 0)
            send_word(MODE_LOAD_B, IDX_W'(r), IDX_W'(c), rand_value());
          send_stray_word();
        end
      send_word(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      if ($urandom_range(0, 4) == 0)
        send_word(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      steady_run = 1'b0;
    end
  endtask

  // main sequence
  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_ROWS_A;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_LOAD_A;
    in_ch.row   <= '0;
    in_ch.col   <= '0;
    in_ch.value <= '0;
    mismatch_count = 0;
    counted_items  = 0;
    steady_run     = 1'b0;
    reg_rows_a     = 4'd8;
    reg_cols_a     = 4'd8;
    reg_rows_b     = 4'd8;
    reg_cols_b     = 4'd8;
    for (int n = 0; n < MAX_DIM*MAX_DIM; n++) begin
      a_elems[n] = '0;
      b_elems[n] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_extremes();
    test_incompatible();
    test_odd_sizes();
    test_random_phases();

    // final drain
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** matrix_multiply_engine_top: PASSED **");
    else
      $display("** matrix_multiply_engine_top: FAILED **");
    $finish;
  end

endmodule
